/* hw/rtl/hpsd_pkg.sv */
// Shared types and constants of the HPACK string literal decoder.
`default_nettype none
package hpsd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int CMP_BITS    = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam int SHIFT_BITS  = $clog2(LENGTH_BITS + 8);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_INT     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADINT = 3'd1;
  localparam logic [2:0] ST_TRUNC  = 3'd2;
  localparam logic [2:0] ST_HUFF   = 3'd3;
  localparam logic [2:0] ST_SPACE  = 3'd4;

  localparam logic [6:0] INT_PREFIX_FULL = 7'h7F;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [SHIFT_BITS-1:0]  shift_t;

  typedef struct packed {
    len_t   sum;
    logic   ovf;
    shift_t shift_next;
  } int_step_t;

endpackage
`default_nettype wire

/* hw/rtl/hpsd_if.sv */
// Byte input and result output channel interfaces of the decoder.
`default_nettype none
interface hpsd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_in;
  logic        end_of_input;
  logic [31:0] dest_space;

  modport source (output valid, byte_in, end_of_input, dest_space, input ready);
  modport sink   (input valid, byte_in, end_of_input, dest_space, output ready);
endinterface

interface hpsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        last;
  logic [2:0]  status;
  logic [31:0] string_length;

  modport source (output valid, data_byte, data_valid, last, status, string_length,
                  input ready);
  modport sink   (input valid, data_byte, data_valid, last, status, string_length,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/hpack_string_literal_decoder.sv */
// HPACK string literal decoder: header integer parse and payload forwarding.
// A byte accepted into the input register is decoded combinationally; its result
// enters the result register once that is empty or read. Throughput: one byte
// per cycle unless str_out stalls; input and result registers decouple both sides.
// Reset (rst, synchronous): both registers empty, decoder waits for a header byte.
`default_nettype none
module hpack_string_literal_decoder
  import hpsd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  hpsd_in_if.sink     str_in,
  hpsd_out_if.source  str_out
);

  // input register
  logic        in_v;
  logic [7:0]  in_byte;
  logic        in_eoi;
  logic [31:0] in_space;

  // decoder state
  logic [1:0]  phase, phase_next;
  len_t        length_accum, length_accum_next;
  shift_t      shift_amount, shift_amount_next;
  len_t        bytes_left, bytes_left_next;
  logic        huffman_seen, huffman_seen_next;
  logic [31:0] space_held, space_held_next;

  // result register
  logic        out_v;
  logic [7:0]  out_byte;
  logic        out_dv;
  logic        out_last;
  logic [2:0]  out_status;
  logic [31:0] out_len;

  logic        adv;
  int_step_t   step;

  logic        res_v;
  logic [7:0]  res_byte;
  logic        res_dv;
  logic        res_last;
  logic [2:0]  res_status;
  logic [31:0] res_len;

  logic        do_done;
  len_t        done_len;
  logic        done_huff;
  logic [31:0] done_space;
  logic [CMP_BITS-1:0] done_len_w;
  logic [CMP_BITS-1:0] accum_w;

  assign adv          = in_v && (!out_v || str_out.ready);
  assign str_in.ready = !in_v || adv;

  hpsd_int_step u_int_step (
    .acc   (length_accum),
    .shift (shift_amount),
    .grp   (in_byte[6:0]),
    .step  (step)
  );

  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    shift_amount_next = shift_amount;
    bytes_left_next   = bytes_left;
    huffman_seen_next = huffman_seen;
    space_held_next   = space_held;
    res_v      = 1'b0;
    res_byte   = 8'd0;
    res_dv     = 1'b0;
    res_last   = 1'b0;
    res_status = ST_OK;
    res_len    = 32'd0;
    do_done    = 1'b0;
    done_len   = length_accum;
    done_huff  = huffman_seen;
    done_space = space_held;
    accum_w    = CMP_BITS'(length_accum);

    unique case (phase)
      PH_HEADER: begin
        space_held_next   = in_space;
        huffman_seen_next = in_byte[7];
        length_accum_next = LENGTH_BITS'(in_byte[6:0]);
        shift_amount_next = '0;
        if (in_byte[6:0] != INT_PREFIX_FULL) begin
          do_done    = 1'b1;
          done_len   = LENGTH_BITS'(in_byte[6:0]);
          done_huff  = in_byte[7];
          done_space = in_space;
        end else if (in_eoi) begin
          res_v      = 1'b1;
          res_last   = 1'b1;
          res_status = ST_BADINT;
          phase_next = PH_HEADER;
        end else begin
          phase_next = PH_INT;
        end
      end
      PH_INT: begin
        if (step.ovf) begin
          res_v      = 1'b1;
          res_last   = 1'b1;
          res_status = ST_BADINT;
          phase_next = in_eoi ? PH_HEADER : PH_DISCARD;
        end else begin
          length_accum_next = step.sum;
          shift_amount_next = step.shift_next;
          if (in_byte[7]) begin
            if (in_eoi) begin
              res_v      = 1'b1;
              res_last   = 1'b1;
              res_status = ST_BADINT;
              phase_next = PH_HEADER;
            end
          end else begin
            do_done  = 1'b1;
            done_len = step.sum;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next = bytes_left - LENGTH_BITS'(1);
        res_v    = 1'b1;
        res_byte = in_byte;
        res_dv   = 1'b1;
        if (bytes_left == LENGTH_BITS'(1)) begin
          res_last   = 1'b1;
          res_len    = accum_w[31:0];
          phase_next = PH_HEADER;
        end else if (in_eoi) begin
          res_last   = 1'b1;
          res_status = ST_TRUNC;
          res_len    = accum_w[31:0];
          phase_next = PH_HEADER;
        end
      end
      PH_DISCARD: begin
        if (in_eoi) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // length known: check truncation, huffman, space, finish an empty string, else start the payload
    done_len_w = CMP_BITS'(done_len);
    if (do_done) begin
      if (done_len != '0 && in_eoi) begin
        res_v      = 1'b1;
        res_last   = 1'b1;
        res_status = ST_TRUNC;
        res_len    = done_len_w[31:0];
        phase_next = PH_HEADER;
      end else if (done_huff) begin
        res_v      = 1'b1;
        res_last   = 1'b1;
        res_status = ST_HUFF;
        res_len    = done_len_w[31:0];
        phase_next = in_eoi ? PH_HEADER : PH_DISCARD;
      end else if (done_len_w > CMP_BITS'(done_space)) begin
        res_v      = 1'b1;
        res_last   = 1'b1;
        res_status = ST_SPACE;
        res_len    = done_len_w[31:0];
        phase_next = in_eoi ? PH_HEADER : PH_DISCARD;
      end else if (done_len == '0) begin
        res_v      = 1'b1;
        res_last   = 1'b1;
        phase_next = PH_HEADER;
      end else begin
        bytes_left_next = done_len;
        phase_next      = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v         <= 1'b0;
      out_v        <= 1'b0;
      phase        <= PH_HEADER;
      length_accum <= '0;
      shift_amount <= '0;
      bytes_left   <= '0;
      huffman_seen <= 1'b0;
      space_held   <= '0;
    end else begin
      if (str_in.valid && str_in.ready) begin
        in_v <= 1'b1;
      end else if (adv) begin
        in_v <= 1'b0;
      end
      if (adv) begin
        out_v        <= res_v;
        phase        <= phase_next;
        length_accum <= length_accum_next;
        shift_amount <= shift_amount_next;
        bytes_left   <= bytes_left_next;
        huffman_seen <= huffman_seen_next;
        space_held   <= space_held_next;
      end else if (str_out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // payload registers: load on request and on decode
  always_ff @(posedge clk) begin
    if (str_in.valid && str_in.ready) begin
      in_byte  <= str_in.byte_in;
      in_eoi   <= str_in.end_of_input;
      in_space <= str_in.dest_space;
    end
    if (adv) begin
      out_byte   <= res_byte;
      out_dv     <= res_dv;
      out_last   <= res_last;
      out_status <= res_status;
      out_len    <= res_len;
    end
  end

  assign str_out.valid         = out_v;
  assign str_out.data_byte     = out_byte;
  assign str_out.data_valid    = out_dv;
  assign str_out.last          = out_last;
  assign str_out.status        = out_status;
  assign str_out.string_length = out_len;

endmodule
`default_nettype wire

/* hw/rtl/hpsd_int_step.sv */
// One continuation byte step of the HPACK prefix integer, with overflow check.
`default_nettype none
module hpsd_int_step
  import hpsd_pkg::*;
(
  input  wire len_t       acc,
  input  wire shift_t     shift,
  input  wire logic [6:0] grp,
  output int_step_t       step
);

  logic [LENGTH_BITS+6:0] wide;
  logic [LENGTH_BITS:0]   total;
  logic [SHIFT_BITS-1:0]  shift_plus;

  always_comb begin
    // shift saturates at LENGTH_BITS, so the lost bits all land in the top group
    wide       = {{LENGTH_BITS{1'b0}}, grp} << shift;
    total      = {1'b0, acc} + {1'b0, wide[LENGTH_BITS-1:0]};
    shift_plus = shift + SHIFT_BITS'(7);
    step.sum   = total[LENGTH_BITS-1:0];
    step.ovf   = (|wide[LENGTH_BITS+6:LENGTH_BITS]) | total[LENGTH_BITS];
    if (shift_plus > SHIFT_BITS'(LENGTH_BITS)) begin
      step.shift_next = SHIFT_BITS'(LENGTH_BITS);
    end else begin
      step.shift_next = shift_plus;
    end
  end

endmodule
`default_nettype wire
